// ===== rtl/cpf_pkg.sv =====
// Package for the closest point pair finder.
// Holds the token that travels along the cell chain and shared helpers.
// Used by cpf_cell, cpf_tail and closest_point_pair_finder.
`timescale 1ns / 1ps

package cpf_pkg;

	localparam int COORD_W   = 16;
	localparam int SQ_W      = 32;
	localparam int SUM_W     = 33;
	localparam int BEST_W    = 34;
	localparam int OUT_IDX_W = 8;

	localparam logic [BEST_W-1:0] DIST_INIT = '1;

	typedef struct packed {
		logic                      valid;
		logic                      is_point;
		logic                      last;
		logic                      found;
		logic                      overflow;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [BEST_W-1:0]         best_dist;
		logic signed [COORD_W-1:0] best_x;
		logic signed [COORD_W-1:0] best_y;
		logic                      pend_valid;
		logic [SQ_W-1:0]           pend_dx2;
		logic [SQ_W-1:0]           pend_dy2;
		logic signed [COORD_W-1:0] pend_x;
		logic signed [COORD_W-1:0] pend_y;
	} cpf_tok_t;

	function automatic logic [SUM_W-1:0] pend_sum(input logic [SQ_W-1:0] a,
			input logic [SQ_W-1:0] b);
		return {1'b0, a} + {1'b0, b};
	endfunction

	function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		logic [COORD_W:0] d;
		logic [COORD_W:0] m;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		m = d[COORD_W] ? (~d + 1'b1) : d;
		return m[COORD_W-1:0] * m[COORD_W-1:0];
	endfunction

endpackage

// ===== rtl/cpf_cell.sv =====
// One cell of the comparison chain: stores one point and compares passing items.
// Depends on cpf_pkg for the chain token and the distance helpers.
`timescale 1ns / 1ps

module cpf_cell #(
	parameter int CELL_INDEX = 0,
	parameter int IDX_W      = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  cpf_pkg::cpf_tok_t    tok_i,
	input  logic [IDX_W-1:0]     idx_i,
	input  logic [IDX_W-1:0]     best_idx_i,
	input  logic [IDX_W-1:0]     pend_idx_i,
	output cpf_pkg::cpf_tok_t    tok_o,
	output logic [IDX_W-1:0]     idx_o,
	output logic [IDX_W-1:0]     best_idx_o,
	output logic [IDX_W-1:0]     pend_idx_o
);
	import cpf_pkg::*;

	localparam logic [IDX_W-1:0] KI = IDX_W'(CELL_INDEX);

	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic                      valid_q;
	cpf_tok_t                  tok_q;
	logic [IDX_W-1:0]          idx_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic [IDX_W-1:0]          pend_idx_q;

	logic [SUM_W-1:0]          sum;
	logic                      better;
	logic                      cmp;
	cpf_tok_t                  tok_n;
	logic [IDX_W-1:0]          best_idx_n;

	always_comb begin
		sum        = pend_sum(tok_i.pend_dx2, tok_i.pend_dy2);
		better     = tok_i.pend_valid && ({1'b0, sum} < tok_i.best_dist);
		cmp        = tok_i.valid && tok_i.is_point && (KI < idx_i);
		tok_n      = tok_i;
		best_idx_n = best_idx_i;
		if (better) begin
			tok_n.best_dist = {1'b0, sum};
			tok_n.best_x    = tok_i.pend_x;
			tok_n.best_y    = tok_i.pend_y;
			best_idx_n      = pend_idx_i;
		end
		tok_n.pend_valid = cmp;
		tok_n.pend_dx2   = sq_diff(tok_i.x, x_q);
		tok_n.pend_dy2   = sq_diff(tok_i.y, y_q);
		tok_n.pend_x     = x_q;
		tok_n.pend_y     = y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tok_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q      <= tok_n;
			idx_q      <= idx_i;
			best_idx_q <= best_idx_n;
			pend_idx_q <= KI;
			if (tok_i.valid && tok_i.is_point && (idx_i == KI)) begin
				x_q <= tok_i.x;
				y_q <= tok_i.y;
			end
		end
	end

	always_comb begin
		tok_o       = tok_q;
		tok_o.valid = valid_q;
	end

	assign idx_o      = idx_q;
	assign best_idx_o = best_idx_q;
	assign pend_idx_o = pend_idx_q;

endmodule

// ===== rtl/cpf_tail.sv =====
// End of the chain: settles the last comparison, merges each item's best pair
// into the set's best in arrival order, and holds the result register.
// Depends on cpf_pkg.
`timescale 1ns / 1ps

module cpf_tail #(
	parameter int IDX_W = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cpf_pkg::cpf_tok_t                     tok_i,
	input  logic [IDX_W-1:0]                      idx_i,
	input  logic [IDX_W-1:0]                      best_idx_i,
	input  logic [IDX_W-1:0]                      pend_idx_i,
	input  logic                                  out_stall,
	output logic                                  adv,
	output logic                                  out_valid,
	output logic                                  found,
	output logic                                  overflow,
	output logic [cpf_pkg::OUT_IDX_W-1:0]         first_index,
	output logic [cpf_pkg::OUT_IDX_W-1:0]         second_index,
	output logic signed [cpf_pkg::COORD_W-1:0]    first_x,
	output logic signed [cpf_pkg::COORD_W-1:0]    first_y,
	output logic signed [cpf_pkg::COORD_W-1:0]    second_x,
	output logic signed [cpf_pkg::COORD_W-1:0]    second_y,
	output logic [cpf_pkg::SUM_W-1:0]             dist_squared
);
	import cpf_pkg::*;

	logic                      s1_valid;
	logic                      s1_point;
	logic                      s1_last;
	logic                      s1_found;
	logic                      s1_overflow;
	logic [BEST_W-1:0]         s1_dist;
	logic [IDX_W-1:0]          s1_fidx;
	logic signed [COORD_W-1:0] s1_fx;
	logic signed [COORD_W-1:0] s1_fy;
	logic [IDX_W-1:0]          s1_sidx;
	logic signed [COORD_W-1:0] s1_sx;
	logic signed [COORD_W-1:0] s1_sy;

	logic [BEST_W-1:0]         g_dist_q;
	logic [IDX_W-1:0]          g_fidx_q;
	logic [IDX_W-1:0]          g_sidx_q;
	logic signed [COORD_W-1:0] g_fx_q;
	logic signed [COORD_W-1:0] g_fy_q;
	logic signed [COORD_W-1:0] g_sx_q;
	logic signed [COORD_W-1:0] g_sy_q;

	logic                      out_valid_q;
	logic                      found_q;
	logic                      overflow_q;
	logic [OUT_IDX_W-1:0]      fidx_q;
	logic [OUT_IDX_W-1:0]      sidx_q;
	logic signed [COORD_W-1:0] fx_q;
	logic signed [COORD_W-1:0] fy_q;
	logic signed [COORD_W-1:0] sx_q;
	logic signed [COORD_W-1:0] sy_q;
	logic [SUM_W-1:0]          dist_q;

	logic [SUM_W-1:0]          sum;
	logic                      pend_better;
	logic                      take;
	logic                      deliver;
	logic [BEST_W-1:0]         m_dist;
	logic [IDX_W-1:0]          m_fidx;
	logic [IDX_W-1:0]          m_sidx;
	logic signed [COORD_W-1:0] m_fx;
	logic signed [COORD_W-1:0] m_fy;
	logic signed [COORD_W-1:0] m_sx;
	logic signed [COORD_W-1:0] m_sy;

	assign adv     = !(out_valid_q && out_stall && s1_valid && s1_last);
	assign deliver = adv && s1_valid && s1_last;

	always_comb begin
		sum         = pend_sum(tok_i.pend_dx2, tok_i.pend_dy2);
		pend_better = tok_i.pend_valid && ({1'b0, sum} < tok_i.best_dist);
		take        = s1_valid && s1_point && (s1_dist < g_dist_q);
		m_dist      = take ? s1_dist : g_dist_q;
		m_fidx      = take ? s1_fidx : g_fidx_q;
		m_sidx      = take ? s1_sidx : g_sidx_q;
		m_fx        = take ? s1_fx : g_fx_q;
		m_fy        = take ? s1_fy : g_fy_q;
		m_sx        = take ? s1_sx : g_sx_q;
		m_sy        = take ? s1_sy : g_sy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (adv) begin
			s1_valid <= tok_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_point    <= tok_i.is_point;
			s1_last     <= tok_i.last;
			s1_found    <= tok_i.found;
			s1_overflow <= tok_i.overflow;
			s1_sidx     <= idx_i;
			s1_sx       <= tok_i.x;
			s1_sy       <= tok_i.y;
			s1_dist     <= pend_better ? {1'b0, sum} : tok_i.best_dist;
			s1_fidx     <= pend_better ? pend_idx_i : best_idx_i;
			s1_fx       <= pend_better ? tok_i.pend_x : tok_i.best_x;
			s1_fy       <= pend_better ? tok_i.pend_y : tok_i.best_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_dist_q <= DIST_INIT;
			g_fidx_q <= '0;
			g_sidx_q <= '0;
		end else if (adv && s1_valid) begin
			if (s1_last) begin
				g_dist_q <= DIST_INIT;
				g_fidx_q <= '0;
				g_sidx_q <= '0;
			end else begin
				g_dist_q <= m_dist;
				g_fidx_q <= m_fidx;
				g_sidx_q <= m_sidx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid && !s1_last) begin
			g_fx_q <= m_fx;
			g_fy_q <= m_fy;
			g_sx_q <= m_sx;
			g_sy_q <= m_sy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deliver) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			found_q    <= s1_found;
			overflow_q <= s1_overflow;
			if (s1_found) begin
				fidx_q <= OUT_IDX_W'(m_fidx);
				sidx_q <= OUT_IDX_W'(m_sidx);
				fx_q   <= m_fx;
				fy_q   <= m_fy;
				sx_q   <= m_sx;
				sy_q   <= m_sy;
				dist_q <= m_dist[SUM_W-1:0];
			end else begin
				fidx_q <= '0;
				sidx_q <= '0;
				fx_q   <= '0;
				fy_q   <= '0;
				sx_q   <= '0;
				sy_q   <= '0;
				dist_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign overflow     = overflow_q;
	assign first_index  = fidx_q;
	assign second_index = sidx_q;
	assign first_x      = fx_q;
	assign first_y      = fy_q;
	assign second_x     = sx_q;
	assign second_y     = sy_q;
	assign dist_squared = dist_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> (out_valid_q && s1_valid && s1_last))
		else $error("chain held without a waiting result");

	a_empty_set_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (dist_squared == '0 && first_index == '0
			&& second_index == '0))
		else $error("result without a pair carries nonzero fields");

	a_found_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s1_valid && s1_last && s1_found) |-> (m_dist != DIST_INIT))
		else $error("set with two points closed without a pair");
`endif

endmodule

// ===== rtl/closest_point_pair_finder.sv =====
// Top level of the closest point pair finder: arrival counter, cell chain and tail.
// Depends on cpf_pkg, cpf_cell and cpf_tail.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid, in_stall   x_coord, y_coord, last
//   out      from block out_valid, out_stall found, overflow, first_index, second_index,
//                                             first_x, first_y, second_x, second_y,
//                                             dist_squared
//
// One point is accepted per cycle while in_stall is low; each point walks the row of
// MAX_POINTS cells and is compared with the points stored earlier in its set. A result is
// registered once the item with last set has passed every cell and the tail stage s1.
// Reset clears the counter, valid bits, best distance and indices; stored points need none.
// in_stall rises only when a result waits under out_stall and the next closing item
// has reached the end of the chain; the whole chain then holds.
`timescale 1ns / 1ps

module closest_point_pair_finder #(
	parameter int MAX_POINTS = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [cpf_pkg::COORD_W-1:0]    x_coord,
	input  logic signed [cpf_pkg::COORD_W-1:0]    y_coord,
	input  logic                                  last,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  found,
	output logic                                  overflow,
	output logic [cpf_pkg::OUT_IDX_W-1:0]         first_index,
	output logic [cpf_pkg::OUT_IDX_W-1:0]         second_index,
	output logic signed [cpf_pkg::COORD_W-1:0]    first_x,
	output logic signed [cpf_pkg::COORD_W-1:0]    first_y,
	output logic signed [cpf_pkg::COORD_W-1:0]    second_x,
	output logic signed [cpf_pkg::COORD_W-1:0]    second_y,
	output logic [cpf_pkg::SUM_W-1:0]             dist_squared
);
	import cpf_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

	logic             adv;
	logic             accept;
	logic             room;
	logic [CNT_W-1:0] count_q;
	logic             drop_q;

	cpf_tok_t         tok   [0:MAX_POINTS];
	logic [IDX_W-1:0] idx   [0:MAX_POINTS];
	logic [IDX_W-1:0] bidx  [0:MAX_POINTS];
	logic [IDX_W-1:0] pidx  [0:MAX_POINTS];

	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign room     = count_q < CNT_MAX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (accept) begin
			if (last) begin
				count_q <= '0;
				drop_q  <= 1'b0;
			end else begin
				count_q <= count_q + CNT_W'(room);
				drop_q  <= drop_q | !room;
			end
		end
	end

	always_comb begin
		tok[0]            = '0;
		tok[0].valid      = accept;
		tok[0].is_point   = room;
		tok[0].last       = last;
		tok[0].found      = room ? (count_q >= CNT_W'(1)) : (count_q >= CNT_W'(2));
		tok[0].overflow   = drop_q | !room;
		tok[0].x          = x_coord;
		tok[0].y          = y_coord;
		tok[0].best_dist  = DIST_INIT;
		tok[0].pend_valid = 1'b0;
		idx[0]            = count_q[IDX_W-1:0];
		bidx[0]           = '0;
		pidx[0]           = '0;
	end

	for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
		cpf_cell #(
			.CELL_INDEX(k),
			.IDX_W     (IDX_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.tok_i     (tok[k]),
			.idx_i     (idx[k]),
			.best_idx_i(bidx[k]),
			.pend_idx_i(pidx[k]),
			.tok_o     (tok[k+1]),
			.idx_o     (idx[k+1]),
			.best_idx_o(bidx[k+1]),
			.pend_idx_o(pidx[k+1])
		);
	end

	cpf_tail #(
		.IDX_W(IDX_W)
	) u_tail (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok_i       (tok[MAX_POINTS]),
		.idx_i       (idx[MAX_POINTS]),
		.best_idx_i  (bidx[MAX_POINTS]),
		.pend_idx_i  (pidx[MAX_POINTS]),
		.out_stall   (out_stall),
		.adv         (adv),
		.out_valid   (out_valid),
		.found       (found),
		.overflow    (overflow),
		.first_index (first_index),
		.second_index(second_index),
		.first_x     (first_x),
		.first_y     (first_y),
		.second_x    (second_x),
		.second_y    (second_y),
		.dist_squared(dist_squared)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("point count beyond capacity");

	a_count_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (count_q == '0 && !drop_q))
		else $error("set state not cleared after closing item");

	a_drop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !last && !room) |=> drop_q)
		else $error("dropped point not flagged");
`endif

endmodule

// ===== test/tb.sv =====
// Testbench for closest_point_pair_finder: sends sets of 2D points and checks each closest-pair
// result against an in-bench tracker of the nearest pair, with random idle and stall cycles.
// Depends on cpf_pkg and the closest_point_pair_finder RTL.
`timescale 1ns / 1ps

module tb;
	localparam int CAPACITY = 256;
	localparam int LATENCY = CAPACITY + 2;
	localparam int RANDOM_ITEMS = 880;

	typedef logic signed [cpf_pkg::COORD_W-1:0] coord_t;
	typedef logic [cpf_pkg::BEST_W-1:0] wide_dist_t;

	typedef struct packed {
		logic                            found;
		logic                            overflow;
		logic [cpf_pkg::OUT_IDX_W-1:0]   first_index;
		logic [cpf_pkg::OUT_IDX_W-1:0]   second_index;
		coord_t                          first_x;
		coord_t                          first_y;
		coord_t                          second_x;
		coord_t                          second_y;
		logic [cpf_pkg::SUM_W-1:0]       dist_squared;
	} pair_report_t;

	typedef enum int {SPREAD, CLUSTER, EDGES} coord_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	coord_t x_coord;
	coord_t y_coord;
	logic last;
	logic out_valid;
	logic out_stall;
	logic found;
	logic overflow;
	logic [cpf_pkg::OUT_IDX_W-1:0] first_index;
	logic [cpf_pkg::OUT_IDX_W-1:0] second_index;
	coord_t first_x;
	coord_t first_y;
	coord_t second_x;
	coord_t second_y;
	logic [cpf_pkg::SUM_W-1:0] dist_squared;

	coord_t set_x [CAPACITY];
	coord_t set_y [CAPACITY];
	int set_size;
	wide_dist_t near_dist;
	int near_a;
	int near_b;
	logic set_dropped;

	pair_report_t pending_pairs[$];
	int fault_count = 0;
	int tx_max;
	int rx_max;
	int hold_left = 0;

	closest_point_pair_finder #(.MAX_POINTS(CAPACITY)) uut (.*);

	always #5 clk = ~clk;

	function automatic wide_dist_t gap_sq(coord_t a, coord_t b);
		longint diff;
		diff = longint'(a) - longint'(b);
		return wide_dist_t'(diff * diff);
	endfunction

	function automatic void clear_set();
		set_size = 0;
		near_dist = cpf_pkg::DIST_INIT;
		near_a = 0;
		near_b = 0;
		set_dropped = 1'b0;
	endfunction

	function automatic void track_point(coord_t x, coord_t y, logic closes);
		wide_dist_t d;
		pair_report_t r;
		if (set_size < CAPACITY) begin
			for (int i = 0; i < set_size; i++) begin
				d = gap_sq(x, set_x[i]) + gap_sq(y, set_y[i]);
				if (d < near_dist) begin
					near_dist = d;
					near_a = i;
					near_b = set_size;
				end
			end
			set_x[set_size] = x;
			set_y[set_size] = y;
			set_size++;
		end else begin
			set_dropped = 1'b1;
		end
		if (closes) begin
			r = '0;
			r.overflow = set_dropped;
			if (set_size >= 2) begin
				r.found = 1'b1;
				r.first_index = near_a[cpf_pkg::OUT_IDX_W-1:0];
				r.second_index = near_b[cpf_pkg::OUT_IDX_W-1:0];
				r.first_x = set_x[near_a];
				r.first_y = set_y[near_a];
				r.second_x = set_x[near_b];
				r.second_y = set_y[near_b];
				r.dist_squared = near_dist[cpf_pkg::SUM_W-1:0];
			end
			pending_pairs = {pending_pairs, r};
			clear_set();
		end
	endfunction

	function automatic string describe(pair_report_t r);
		return $sformatf("found=%0b ovf=%0b idx=%0d,%0d p0=(%0d,%0d) p1=(%0d,%0d) d2=%0d",
			r.found, r.overflow, r.first_index, r.second_index, r.first_x, r.first_y,
			r.second_x, r.second_y, r.dist_squared);
	endfunction

	function automatic coord_t rand_coord(coord_mode_t mode);
		int v;
		case (mode)
			CLUSTER: v = $urandom_range(0, 8) - 4;
			EDGES: v = $urandom_range(0, 1) ? -32768 + $urandom_range(0, 3)
				: 32767 - $urandom_range(0, 3);
			default: v = $urandom;
		endcase
		return coord_t'(v);
	endfunction

	task automatic send_point(coord_t x, coord_t y, logic closes);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		last <= closes;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_point(x, y, closes);
	endtask

	task automatic send_set(int count, coord_mode_t mode);
		for (int i = 0; i < count; i++) begin
			send_point(rand_coord(mode), rand_coord(mode), i == count - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic test_extremes();
		send_point(-16'sd32768, 16'sd32767, 1'b1);
		send_point(-16'sd32768, -16'sd32768, 1'b0);
		send_point(16'sd32767, 16'sd32767, 1'b1);
		send_point(16'sd32767, -16'sd32768, 1'b0);
		send_point(-16'sd32768, 16'sd32767, 1'b1);
		send_point(-16'sd1, 16'sd0, 1'b0);
		send_point(16'sd0, -16'sd1, 1'b1);
		send_point(16'sh5555, -16'sh5556, 1'b0);
		send_point(-16'sh5556, 16'sh5555, 1'b1);
	endtask

	task automatic test_ties();
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd1, 16'sd0, 1'b0);
		send_point(16'sd2, 16'sd0, 1'b0);
		send_point(16'sd1, 16'sd0, 1'b1);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd2, 16'sd0, 1'b0);
		send_point(16'sd1, 16'sd0, 1'b1);
		send_point(16'sd3, 16'sd4, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(-16'sd3, -16'sd4, 1'b1);
		drain();
	endtask

	task automatic test_capacity();
		coord_t px;
		coord_t py;
		for (int i = 0; i < CAPACITY - 1; i++) begin
			px = rand_coord(SPREAD);
			py = rand_coord(SPREAD);
			send_point(px, py, 1'b0);
		end
		send_point(px, py, 1'b1);
		send_set(CAPACITY + 1, SPREAD);
		for (int i = 0; i < CAPACITY; i++) begin
			send_point(coord_t'(i * 200), coord_t'(-i * 100), 1'b0);
		end
		send_point(coord_t'(5), coord_t'(0), 1'b0);
		send_point(coord_t'(0), coord_t'(1), 1'b1);
		send_set(CAPACITY + 4, CLUSTER);
		drain();
	endtask

	task automatic test_random();
		int sent;
		int pick;
		int count;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				count = $urandom_range(CAPACITY - 1, CAPACITY + 3);
			end else if (pick < 20) begin
				count = $urandom_range(13, 48);
			end else begin
				count = $urandom_range(1, 12);
			end
			tx_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			rx_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			send_set(count, coord_mode_t'($urandom_range(0, 2)));
			sent += count;
			if ($urandom_range(0, 30) == 0) begin
				drain();
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_pairs.size() == 0) begin
					if (fault_count < 10) begin
						$display("unexpected result: %s", describe({found, overflow,
							first_index, second_index, first_x, first_y, second_x,
							second_y, dist_squared}));
					end
					fault_count++;
				end else if ({found, overflow, first_index, second_index, first_x, first_y,
						second_x, second_y, dist_squared} !== pending_pairs[0]) begin
					if (fault_count < 10) begin
						$display("mismatch: expected %s", describe(pending_pairs[0]));
						$display("          actual   %s", describe({found, overflow,
							first_index, second_index, first_x, first_y, second_x,
							second_y, dist_squared}));
					end
					fault_count++;
					void'(pending_pairs.pop_front());
				end else begin
					void'(pending_pairs.pop_front());
				end
				hold_left = $urandom_range(0, rx_max);
			end else if (out_valid && hold_left > 0) begin
				hold_left--;
			end
			out_stall <= (hold_left != 0);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		x_coord = '0;
		y_coord = '0;
		last = 1'b0;
		out_stall = 1'b0;
		tx_max = 4;
		rx_max = 4;
		clear_set();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_ties();
		test_capacity();
		test_random();
		drain();
		if (fault_count == 0 && pending_pairs.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
